>>> src/tssfl_pkg.sv
package tssfl_pkg;

	localparam int POOL_DEPTH_DEF = 32;
	localparam int NUM_STACKS_DEF = 3;
	localparam int DATA_WIDTH_DEF = 32;

	localparam int REQ_TYPE_W = 2;
	localparam int STACK_ID_W = 2;
	localparam int VALUE_W    = 32;
	localparam int STATUS_W   = 2;
	localparam int DEPTH_W    = 6;

	localparam logic [REQ_TYPE_W-1:0] REQ_PUSH = 2'd0;
	localparam logic [REQ_TYPE_W-1:0] REQ_POP  = 2'd1;
	localparam logic [REQ_TYPE_W-1:0] REQ_PEEK = 2'd2;

	localparam logic [STATUS_W-1:0] STAT_OK       = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_OVERFLOW = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_EMPTY    = 2'd2;

	typedef struct packed {
		logic [REQ_TYPE_W-1:0]    req_type;
		logic [STACK_ID_W-1:0]    stack_id;
		logic signed [VALUE_W-1:0] push_value;
	} req_t;

	typedef struct packed {
		logic [STATUS_W-1:0]       status;
		logic signed [VALUE_W-1:0] top_value;
		logic [DEPTH_W-1:0]        stack_depth;
		logic                      stack_empty;
		logic [DEPTH_W-1:0]        free_slots;
	} rsp_t;

	typedef struct packed {
		logic init_wr;
		logic accept;
		logic commit;
	} ctrl_cmd_t;

	typedef struct packed {
		logic init_last;
		logic out_busy;
	} ctrl_sts_t;

endpackage

>>> src/tssfl_ram.sv
module tssfl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 32
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> src/tssfl_ctrl.sv
module tssfl_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_ready,
	input  tssfl_pkg::ctrl_sts_t  sts,
	output tssfl_pkg::ctrl_cmd_t  cmd
);
	import tssfl_pkg::*;

	localparam logic [1:0] ST_INIT = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [1:0] state_nx;

	always_comb begin
		state_nx    = state_q;
		cmd.init_wr = 1'b0;
		cmd.accept  = 1'b0;
		cmd.commit  = 1'b0;
		req_ready   = 1'b0;
		case (state_q)
			ST_INIT: begin
				cmd.init_wr = 1'b1;
				if (sts.init_last) begin
					state_nx = ST_IDLE;
				end
			end
			ST_IDLE: begin
				req_ready  = 1'b1;
				cmd.accept = req_valid;
				if (req_valid) begin
					state_nx = ST_EXEC;
				end
			end
			ST_EXEC: begin
				if (!sts.out_busy) begin
					cmd.commit = 1'b1;
					state_nx   = ST_IDLE;
				end
			end
			default: begin
				state_nx = ST_INIT;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
		end else begin
			state_q <= state_nx;
		end
	end

	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.accept |=> (state_q == ST_EXEC) && !req_ready)
		else $error("accepted word did not move to execute");

	a_commit_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (state_q == ST_IDLE))
		else $error("commit did not return to idle");

	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !req_ready)
		else $error("ready raised outside idle");

endmodule

>>> src/tssfl_dp.sv
module tssfl_dp #(
	parameter int POOL_DEPTH = tssfl_pkg::POOL_DEPTH_DEF,
	parameter int NUM_STACKS = tssfl_pkg::NUM_STACKS_DEF,
	parameter int DATA_WIDTH = tssfl_pkg::DATA_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tssfl_pkg::req_t      req,
	output tssfl_pkg::rsp_t      rsp,
	output logic                 rsp_valid,
	input  logic                 rsp_ready,
	input  tssfl_pkg::ctrl_cmd_t cmd,
	output tssfl_pkg::ctrl_sts_t sts
);
	import tssfl_pkg::*;

	localparam int AW  = $clog2(POOL_DEPTH);
	localparam int CW  = $clog2(POOL_DEPTH + 1);
	localparam int SIW = (NUM_STACKS > 1) ? $clog2(NUM_STACKS) : 1;
	localparam int RW  = DATA_WIDTH + AW;

	req_t                  req_q;
	logic [SIW-1:0]        sidx_in;
	logic                  sid_ok_in;
	logic [SIW-1:0]        sidx_q;
	logic                  sid_ok_q;

	logic [AW-1:0]         head_q [NUM_STACKS];
	logic [CW-1:0]         cnt_q  [NUM_STACKS];
	logic [DATA_WIDTH-1:0] top_q  [NUM_STACKS];
	logic [AW-1:0]         sel_head_q;
	logic [CW-1:0]         sel_cnt_q;
	logic [DATA_WIDTH-1:0] sel_top_q;
	logic [AW-1:0]         free_head_q;
	logic [CW-1:0]         free_cnt_q;
	logic [AW-1:0]         clr_q;

	logic                  ram_we;
	logic [AW-1:0]         ram_waddr;
	logic [RW-1:0]         ram_wdata;
	logic [AW-1:0]         ram_raddr;
	logic [RW-1:0]         ram_rdata;
	logic [AW-1:0]         rd_link;
	logic [DATA_WIDTH-1:0] rd_below;

	logic                  is_push;
	logic                  is_pop;
	logic                  do_push;
	logic                  do_pop;
	logic [STATUS_W-1:0]   status_nx;
	logic [CW-1:0]         cnt_nx;
	logic [CW-1:0]         free_nx;
	logic [DATA_WIDTH-1:0] top_nx;
	logic [63:0]           pv_ext;
	logic [63:0]           top_ext;
	logic [31:0]           depth_ext;
	logic [31:0]           free_ext;
	logic                  empty_nx;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;
	logic [31:0]           occ_total;

	always_comb begin
		sidx_in   = '0;
		sid_ok_in = 1'b0;
		for (int i = 0; i < NUM_STACKS; i++) begin
			if (int'(req.stack_id) == i) begin
				sidx_in   = SIW'(i);
				sid_ok_in = 1'b1;
			end
		end
	end

	assign ram_raddr = (req.req_type == REQ_PUSH) ? free_head_q : head_q[sidx_in];
	assign rd_link   = ram_rdata[AW-1:0];
	assign rd_below  = ram_rdata[RW-1:AW];

	tssfl_ram #(
		.WIDTH(RW),
		.DEPTH(POOL_DEPTH)
	) u_pool (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (cmd.accept),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// latch the addressed stack once per word
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			req_q      <= req;
			sidx_q     <= sidx_in;
			sid_ok_q   <= sid_ok_in;
			sel_head_q <= head_q[sidx_in];
			sel_cnt_q  <= cnt_q[sidx_in];
			sel_top_q  <= top_q[sidx_in];
		end
	end

	assign is_push = (req_q.req_type == REQ_PUSH);
	assign is_pop  = (req_q.req_type == REQ_POP);
	assign do_push = sid_ok_q && is_push && (free_cnt_q != '0);
	assign do_pop  = sid_ok_q && is_pop && (sel_cnt_q != '0);
	assign pv_ext  = 64'($unsigned(req_q.push_value));

	always_comb begin
		cnt_nx  = sel_cnt_q;
		free_nx = free_cnt_q;
		top_nx  = sel_top_q;
		if (do_push) begin
			cnt_nx  = sel_cnt_q + CW'(1);
			free_nx = free_cnt_q - CW'(1);
			top_nx  = pv_ext[DATA_WIDTH-1:0];
		end else if (do_pop) begin
			cnt_nx  = sel_cnt_q - CW'(1);
			free_nx = free_cnt_q + CW'(1);
			top_nx  = rd_below;
		end
		if (!sid_ok_q) begin
			status_nx = STAT_OK;
		end else if (is_push) begin
			status_nx = (free_cnt_q == '0) ? STAT_OVERFLOW : STAT_OK;
		end else begin
			status_nx = (sel_cnt_q == '0) ? STAT_EMPTY : STAT_OK;
		end
	end

	assign empty_nx  = !sid_ok_q || (cnt_nx == '0);
	assign top_ext   = 64'(top_nx);
	assign depth_ext = sid_ok_q ? 32'(cnt_nx) : 32'd0;
	assign free_ext  = 32'(free_nx);

	// link entry i to i-1 during the clearing sweep
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = clr_q;
		ram_wdata = {{DATA_WIDTH{1'b0}}, (clr_q == '0) ? {AW{1'b0}} : clr_q - AW'(1)};
		if (cmd.init_wr) begin
			ram_we = 1'b1;
		end else if (cmd.commit && do_push) begin
			ram_we    = 1'b1;
			ram_waddr = free_head_q;
			ram_wdata = {sel_top_q, sel_head_q};
		end else if (cmd.commit && do_pop) begin
			ram_we    = 1'b1;
			ram_waddr = sel_head_q;
			ram_wdata = {rd_below, free_head_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_STACKS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
			free_head_q <= AW'(POOL_DEPTH - 1);
			free_cnt_q  <= CW'(POOL_DEPTH);
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd.init_wr) begin
				clr_q <= clr_q + AW'(1);
			end
			if (cmd.commit) begin
				free_cnt_q <= free_nx;
				if (sid_ok_q) begin
					cnt_q[sidx_q] <= cnt_nx;
				end
				if (do_push) begin
					free_head_q    <= rd_link;
					head_q[sidx_q] <= free_head_q;
				end else if (do_pop) begin
					head_q[sidx_q] <= rd_link;
					free_head_q    <= sel_head_q;
				end
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit && sid_ok_q) begin
			top_q[sidx_q] <= top_nx;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			rsp_q.status      <= status_nx;
			rsp_q.top_value   <= empty_nx ? '0 : $signed(top_ext[VALUE_W-1:0]);
			rsp_q.stack_depth <= depth_ext[DEPTH_W-1:0];
			rsp_q.stack_empty <= empty_nx;
			rsp_q.free_slots  <= free_ext[DEPTH_W-1:0];
		end
	end

	assign rsp           = rsp_q;
	assign rsp_valid     = rsp_valid_q;
	assign sts.init_last = (clr_q == AW'(POOL_DEPTH - 1));
	assign sts.out_busy  = rsp_valid_q && !rsp_ready;

	always_comb begin
		occ_total = 32'(free_cnt_q);
		for (int i = 0; i < NUM_STACKS; i++) begin
			occ_total = occ_total + 32'(cnt_q[i]);
		end
	end

	a_pool_conserved: assert property (@(posedge clk) disable iff (!arst_n)
		occ_total == 32'(POOL_DEPTH))
		else $error("pool entries lost or duplicated");

	a_commit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> rsp_valid_q)
		else $error("committed word not presented");

	a_pop_frees: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.commit && do_pop) |=> (free_cnt_q == $past(free_cnt_q) + CW'(1)))
		else $error("pop did not return entry to free list");

endmodule

>>> src/three_stacks_shared_free_list.sv
// Three LIFO stacks over one shared pool of linked entries, with a LIFO free list.
// Request channel (req_valid/req_ready/req): one word per push, pop or peek on a stack.
// Response channel (rsp_valid/rsp_ready/rsp): one word per request, in order, carrying
// status, the addressed stack's top, depth and emptiness, and the free entry count.
// Each accepted request reads the pool when it is accepted and loads its response register
// when it commits in the execute step; rsp_valid rises after that load.
// A request passes an accept step that reads the pool link/value memory, then an execute
// step that updates pointers and loads the response register; req_ready is low in it.
// The response register parts the two sides: while a response waits, the block holds
// the next request in its execute step until the receiver takes the waiting word.
// Reset: all stacks empty, every pool entry free. After reset a clearing sweep writes
// the free-list link of every pool entry; req_ready stays low during it.
// Each pool entry holds its link and the value beneath it; stack tops sit in registers.
module three_stacks_shared_free_list #(
	parameter int POOL_DEPTH = tssfl_pkg::POOL_DEPTH_DEF,
	parameter int NUM_STACKS = tssfl_pkg::NUM_STACKS_DEF,
	parameter int DATA_WIDTH = tssfl_pkg::DATA_WIDTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_ready,
	input  tssfl_pkg::req_t req,
	output logic            rsp_valid,
	input  logic            rsp_ready,
	output tssfl_pkg::rsp_t rsp
);
	import tssfl_pkg::*;

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	tssfl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_ready(req_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	tssfl_dp #(
		.POOL_DEPTH(POOL_DEPTH),
		.NUM_STACKS(NUM_STACKS),
		.DATA_WIDTH(DATA_WIDTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
